// ===== sv/xtea_pkg.sv =====
// XTEA block cipher package: stage payload type, key type, round constants
// and the mixing function used by the round stages.
// No dependencies.
package xtea_pkg;

    localparam int          DATA_W     = 32;
    localparam int          KEY_WORDS  = 4;
    localparam int          KEY_IDX_W  = 2;
    localparam int          CFG_ADDR_W = 4;
    localparam logic [31:0] XT_DELTA   = 32'h9E37_79B9;

    typedef logic [KEY_WORDS-1:0][DATA_W-1:0] t_key;
    typedef logic [KEY_IDX_W-1:0]             t_key_idx;

    // One pipeline beat: valid bit, mode and both block halves
    typedef struct packed {
        logic              valid;
        logic              mode;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_stage;

    // Shift-xor-add mix of one half
    function automatic logic [DATA_W-1:0] mix(input logic [DATA_W-1:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

// ===== sv/xtea_block_cipher_top.sv =====
// XTEA block cipher top level: key registers and the unrolled round pipeline.
// Depends on xtea_pkg, xtea_cfg_regs and xtea_round_stage.
//
//   channel   | ports                                        | flow
//   ----------+----------------------------------------------+---------------------
//   command   | start, busy, i_mode, i_block_first/second     | beat when start & !busy
//   result    | o_valid, o_out_first, o_out_second            | one-cycle strobe
//   config    | psel, penable, pwrite, paddr, pwdata, prdata  | APB, pready tied high
//
// A block may enter every cycle; busy is never raised.
// Each half-round is one registered pipeline stage.
// Reset clears the key words and every stage valid bit; nothing waits on a
// clearing pass. The result side has no back-pressure, so nothing stalls.
module xtea_block_cipher_top #(
    parameter int ROUNDS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [31:0]                     i_block_first,
    input  logic [31:0]                     i_block_second,
    output logic                            o_valid,
    output logic [31:0]                     o_out_first,
    output logic [31:0]                     o_out_second,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [xtea_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import xtea_pkg::*;

    localparam int LAT = 2 * ROUNDS;

    t_key   w_key;
    t_stage w_pipe [0:LAT];

    assign busy = 1'b0;

    xtea_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (w_key)
    );

    // Launch a beat into the first half-round
    assign w_pipe[0] = '{valid: start && !busy, mode: i_mode,
                         a: i_block_first, b: i_block_second};

    // One stage per half-round
    for (genvar g = 0; g < LAT; g++) begin : g_stage
        xtea_round_stage #(
            .ROUNDS (ROUNDS),
            .STAGE  (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (w_key),
            .i_stage (w_pipe[g]),
            .o_stage (w_pipe[g+1])
        );
    end

    // Drive the result strobe from the last stage
    assign o_valid      = w_pipe[LAT].valid;
    assign o_out_first  = w_pipe[LAT].a;
    assign o_out_second = w_pipe[LAT].b;

    // A result only follows a matching earlier command beat
    a_result_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, LAT))
        else $error("result strobe without matching command beat");

    // A written key word reads back on the next cycle
    a_key_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready) ##1 (paddr[3:2] == $past(paddr[3:2]))
        |-> (prdata == $past(pwdata)))
        else $error("key word readback mismatch");

    // The mode bit of a result beat matches its command beat
    a_mode_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_pipe[LAT].mode == $past(i_mode, LAT)))
        else $error("mode bit lost in pipeline");

endmodule

// ===== sv/xtea_cfg_regs.sv =====
// XTEA key register file behind an APB-style port.
// Depends on xtea_pkg for the key type and address width.
module xtea_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xtea_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output xtea_pkg::t_key                o_key
);
    import xtea_pkg::*;

    t_key     r_key;
    t_key     n_key;
    t_key_idx w_idx;

    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    // Update the addressed key word on the access beat
    always_comb begin
        n_key = r_key;
        if (psel && penable && pwrite) begin
            n_key[w_idx] = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    // Read back the addressed word
    assign prdata = r_key[w_idx];
    assign o_key  = r_key;

endmodule

// ===== sv/xtea_round_stage.sv =====
// One XTEA half-round as a registered pipeline stage; the running sum of
// the stage is a constant set by its position and the beat's mode.
// Depends on xtea_pkg for the beat type, key type and mix function.
module xtea_round_stage #(
    parameter int ROUNDS = 32,
    parameter int STAGE  = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xtea_pkg::t_key   i_key,
    input  xtea_pkg::t_stage i_stage,
    output xtea_pkg::t_stage o_stage
);
    import xtea_pkg::*;

    localparam bit          ODD      = 1'(STAGE % 2);
    localparam logic [31:0] ENC_MULT = 32'((STAGE / 2) + (STAGE % 2));
    localparam logic [31:0] DEC_MULT = 32'(ROUNDS - (STAGE / 2) - (STAGE % 2));
    localparam logic [31:0] ENC_SUM  = 32'(ENC_MULT * XT_DELTA);
    localparam logic [31:0] DEC_SUM  = 32'(DEC_MULT * XT_DELTA);
    localparam t_key_idx    ENC_SEL  = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
    localparam t_key_idx    DEC_SEL  = ODD ? DEC_SUM[1:0]   : DEC_SUM[12:11];

    logic              w_upd_a;
    logic [DATA_W-1:0] w_src;
    logic [DATA_W-1:0] w_tgt;
    logic [DATA_W-1:0] w_mixed;
    logic [DATA_W-1:0] w_kterm;
    logic [DATA_W-1:0] w_f;
    logic [DATA_W-1:0] w_res;

    logic              r_valid;
    logic              r_mode;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;

    // Pick which half gets updated: encrypt starts on a, decrypt on b
    assign w_upd_a = (i_stage.mode == ODD);
    assign w_src   = w_upd_a ? i_stage.b : i_stage.a;
    assign w_tgt   = w_upd_a ? i_stage.a : i_stage.b;

    // Mix and key term in parallel, then fold into the target half
    always_comb begin
        w_mixed = mix(w_src);
        w_kterm = i_stage.mode ? (DEC_SUM + i_key[DEC_SEL]) : (ENC_SUM + i_key[ENC_SEL]);
        w_f     = w_mixed ^ w_kterm;
        w_res   = i_stage.mode ? (w_tgt - w_f) : (w_tgt + w_f);
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    // Hold the payload of the beat
    always_ff @(posedge i_clk) begin
        r_mode <= i_stage.mode;
        r_a    <= w_upd_a ? w_res : i_stage.a;
        r_b    <= w_upd_a ? i_stage.b : w_res;
    end

    assign o_stage = '{valid: r_valid, mode: r_mode, a: r_a, b: r_b};

endmodule
